// ----- hw/rtl/srarq_pkg.sv -----
// Shared types and constants of the selective-repeat ARQ window core.
package srarq_pkg;

  // Most actions a single event can leave in the result queue.
  localparam int unsigned ResultCap = 10;
  localparam int unsigned CntW      = $clog2(ResultCap + 1);

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_PKT_READY   = 3'd0,
    OP_FRAME       = 3'd1,
    OP_CKSUM_ERR   = 3'd2,
    OP_TIMEOUT     = 3'd3,
    OP_ACK_TIMEOUT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_NAK     = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_STOP    = 3'd5
  } act_e;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NOP     = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_PKT     = 4'd2,
    CMD_CKERR   = 4'd3,
    CMD_TIMEOUT = 4'd4,
    CMD_ACKTO   = 4'd5,
    CMD_ARR_NAK = 4'd6,
    CMD_MARK    = 4'd7,
    CMD_DELIVER = 4'd8,
    CMD_RETX    = 4'd9,
    CMD_STOP    = 4'd10,
    CMD_FINISH  = 4'd11,
    CMD_POP     = 4'd12
  } cmd_e;

  // One queued result beat, fields already cut to port width.
  typedef struct packed {
    act_e       action;
    logic [2:0] seq;
    logic [2:0] ack;
    logic [1:0] slot;
  } act_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] kind;
    logic       deliver_pending;
    logic       stop_pending;
    logic       last;
  } dp_status_t;

endpackage

// ----- hw/rtl/srarq_intf.sv -----
// Valid/ready channel interfaces for events in and actions out.
interface srarq_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [1:0] frame_type;
  logic [2:0] frame_seq;
  logic [2:0] frame_ack;
  logic [2:0] timed_out_seq;

  modport source (
    output valid, operation, frame_type, frame_seq, frame_ack, timed_out_seq,
    input  ready
  );
  modport sink (
    input  valid, operation, frame_type, frame_seq, frame_ack, timed_out_seq,
    output ready
  );
endinterface

interface srarq_act_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] seq_out;
  logic [2:0] ack_out;
  logic [1:0] buffer_slot;
  logic       network_enable;
  logic       last;

  modport source (
    output valid, action, seq_out, ack_out, buffer_slot, network_enable, last,
    input  ready
  );
  modport sink (
    input  valid, action, seq_out, ack_out, buffer_slot, network_enable, last,
    output ready
  );
endinterface

// ----- hw/rtl/selective_repeat_arq_window_core.sv -----
// Selective-repeat ARQ sliding-window core: top level.
//
// evt_i takes one link event per beat (packet ready, frame arrival, checksum
// error, timeout, ack timeout). act_o returns the run of actions the event
// causes, one per beat, the final one flagged by last; every beat carries the
// network-enable level taken after the whole event. Payload buffers and timers
// live outside.
// An event is worked one at a time: evt_i.ready is high only while idle.
// The event beat is loaded and decoded; a data frame then passes the arrival
// NAK, mark, delivery and ack states, an ack frame the ack state and a NAK frame
// the retransmit and ack states, after which the result queue is finished and
// drained. The sequencer walks the delivery and ack loops one step per cycle,
// one step per delivered slot and one per acked frame.
// While act_o.ready is low the current action holds and no event is taken.
// Reset (asynchronous, active low) clears both windows, the arrived map and
// buffer count, and allows a NAK; the block is ready in the first cycle after.
module selective_repeat_arq_window_core import srarq_pkg::*; #(
  parameter int unsigned MAX_SEQUENCE = 7,
  parameter int unsigned BUFFER_COUNT = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  srarq_evt_if.sink   evt_i,
  srarq_act_if.source act_o
);

  cmd_e       cmd;
  dp_status_t status;
  act_t       head;
  logic       net_en;

  srarq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (evt_i.valid),
    .in_ready_o  (evt_i.ready),
    .out_valid_o (act_o.valid),
    .out_ready_i (act_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srarq_datapath #(
    .MAX_SEQUENCE (MAX_SEQUENCE),
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (evt_i.operation),
    .frame_type_i     (evt_i.frame_type),
    .frame_seq_i      (evt_i.frame_seq),
    .frame_ack_i      (evt_i.frame_ack),
    .timed_out_seq_i  (evt_i.timed_out_seq),
    .status_o         (status),
    .head_o           (head),
    .network_enable_o (net_en)
  );

  assign act_o.action         = head.action;
  assign act_o.seq_out        = head.seq;
  assign act_o.ack_out        = head.ack;
  assign act_o.buffer_slot    = head.slot;
  assign act_o.network_enable = net_en;
  assign act_o.last           = status.last;

endmodule

// ----- hw/rtl/srarq_datapath.sv -----
// Window state, event latch and result queue of the ARQ core.
module srarq_datapath import srarq_pkg::*; #(
  parameter int unsigned MAX_SEQUENCE = 7,
  parameter int unsigned BUFFER_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  logic [2:0] operation_i,
  input  logic [1:0] frame_type_i,
  input  logic [2:0] frame_seq_i,
  input  logic [2:0] frame_ack_i,
  input  logic [2:0] timed_out_seq_i,
  output dp_status_t status_o,
  output act_t       head_o,
  output logic       network_enable_o
);

  localparam int unsigned SeqSpace = MAX_SEQUENCE + 1;
  localparam int unsigned SeqW     = $clog2(SeqSpace);
  localparam int unsigned SlotW    = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int unsigned BufW     = $clog2(BUFFER_COUNT + 1);
  localparam int unsigned RueInit  = BUFFER_COUNT % SeqSpace;

  typedef logic [SeqW-1:0]  seq_t;
  typedef logic [SlotW-1:0] slot_t;

  // Values here never exceed 8, so eight conditional subtracts suffice.
  function automatic logic [8:0] reduce_seq(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= 9'(SeqSpace)) r = r - 9'(SeqSpace);
    end
    return r;
  endfunction

  function automatic logic [8:0] reduce_slot(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= 9'(BUFFER_COUNT)) r = r - 9'(BUFFER_COUNT);
    end
    return r;
  endfunction

  function automatic seq_t seq_inc(input seq_t s);
    return (s == seq_t'(MAX_SEQUENCE)) ? '0 : seq_t'(s + seq_t'(1));
  endfunction

  // Slot follows its sequence counter; wraps at the buffer count and with it at the top of the space.
  function automatic slot_t slot_inc(input slot_t sl, input seq_t s);
    slot_t r;
    if (s == seq_t'(MAX_SEQUENCE)) r = '0;
    else if (sl == slot_t'(BUFFER_COUNT - 1)) r = '0;
    else r = slot_t'(sl + slot_t'(1));
    return r;
  endfunction

  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [2:0] seq_fld(input seq_t s);
    logic [7:0] w;
    w = 8'(s);
    return w[2:0];
  endfunction

  function automatic logic [1:0] slot_fld(input slot_t s);
    logic [7:0] w;
    w = 8'(s);
    return w[1:0];
  endfunction

  // Window state
  seq_t              ae_q, nts_q, rle_q, rue_q;
  slot_t             ae_slot_q, nts_slot_q, rle_slot_q;
  logic [BufW-1:0]   bufs_q;
  logic [BUFFER_COUNT-1:0] map_q;
  logic              nak_q;

  // Latched event
  logic [2:0] op_q;
  logic [1:0] kind_q;
  seq_t       seq_q, ack_q, tseq_q;

  // Result queue
  act_t q_mem [ResultCap];
  cnt_t cnt_q, rd_q;

  seq_t  piggy, re;
  slot_t seq_slot, re_slot, tseq_slot;
  logic  pkt_ok, mark_ok, retx_ok, stop_ok, arr_nak_ok;
  logic  push;
  act_t  push_ent;

  assign piggy     = (rle_q == '0) ? seq_t'(MAX_SEQUENCE) : seq_t'(rle_q - seq_t'(1));
  assign re        = seq_inc(ack_q);
  assign seq_slot  = slot_t'(reduce_slot(9'(seq_q)));
  assign re_slot   = slot_t'(reduce_slot(9'(re)));
  assign tseq_slot = slot_t'(reduce_slot(9'(tseq_q)));

  assign pkt_ok     = bufs_q < BufW'(BUFFER_COUNT);
  assign mark_ok    = in_window(rle_q, seq_q, rue_q) && !map_q[seq_slot];
  assign retx_ok    = in_window(ae_q, re, nts_q);
  assign stop_ok    = in_window(ae_q, ack_q, nts_q);
  assign arr_nak_ok = (seq_q != rle_q) && nak_q;

  always_comb begin
    push     = 1'b0;
    push_ent = '{action: ACT_NONE, seq: 3'd0, ack: 3'd0, slot: 2'd0};
    unique case (cmd_i)
      CMD_PKT: begin
        push     = pkt_ok;
        push_ent = '{action: ACT_DATA, seq: seq_fld(nts_q), ack: seq_fld(piggy),
                     slot: slot_fld(nts_slot_q)};
      end
      CMD_CKERR, CMD_ARR_NAK: begin
        push     = (cmd_i == CMD_CKERR) ? nak_q : arr_nak_ok;
        push_ent = '{action: ACT_NAK, seq: 3'd0, ack: seq_fld(piggy), slot: 2'd0};
      end
      CMD_TIMEOUT: begin
        push     = 1'b1;
        push_ent = '{action: ACT_DATA, seq: seq_fld(tseq_q), ack: seq_fld(piggy),
                     slot: slot_fld(tseq_slot)};
      end
      CMD_ACKTO: begin
        push     = 1'b1;
        push_ent = '{action: ACT_ACK, seq: 3'd0, ack: seq_fld(piggy), slot: 2'd0};
      end
      CMD_DELIVER: begin
        push     = 1'b1;
        push_ent = '{action: ACT_DELIVER, seq: seq_fld(rle_q), ack: 3'd0,
                     slot: slot_fld(rle_slot_q)};
      end
      CMD_RETX: begin
        push     = retx_ok;
        push_ent = '{action: ACT_DATA, seq: seq_fld(re), ack: seq_fld(piggy),
                     slot: slot_fld(re_slot)};
      end
      CMD_STOP: begin
        push     = 1'b1;
        push_ent = '{action: ACT_STOP, seq: seq_fld(ae_q), ack: 3'd0,
                     slot: slot_fld(ae_slot_q)};
      end
      CMD_FINISH: begin
        push = (cnt_q == '0);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ae_q       <= '0;
      nts_q      <= '0;
      rle_q      <= '0;
      rue_q      <= seq_t'(RueInit);
      ae_slot_q  <= '0;
      nts_slot_q <= '0;
      rle_slot_q <= '0;
      bufs_q     <= '0;
      map_q      <= '0;
      nak_q      <= 1'b1;
      cnt_q      <= '0;
      rd_q       <= '0;
    end else begin
      // beats past the cap are dropped; state still moves
      if (push && (cnt_q < cnt_t'(ResultCap))) cnt_q <= cnt_t'(cnt_q + cnt_t'(1));
      unique case (cmd_i)
        CMD_LOAD: begin
          cnt_q <= '0;
          rd_q  <= '0;
        end
        CMD_PKT: begin
          if (pkt_ok) begin
            bufs_q     <= BufW'(bufs_q + BufW'(1));
            nts_q      <= seq_inc(nts_q);
            nts_slot_q <= slot_inc(nts_slot_q, nts_q);
          end
        end
        CMD_CKERR: begin
          nak_q <= 1'b0;
        end
        CMD_ARR_NAK: begin
          if (arr_nak_ok) nak_q <= 1'b0;
        end
        CMD_MARK: begin
          if (mark_ok) map_q[seq_slot] <= 1'b1;
        end
        CMD_DELIVER: begin
          nak_q             <= 1'b1;
          map_q[rle_slot_q] <= 1'b0;
          rle_q             <= seq_inc(rle_q);
          rle_slot_q        <= slot_inc(rle_slot_q, rle_q);
          rue_q             <= seq_inc(rue_q);
        end
        CMD_STOP: begin
          if (bufs_q != '0) bufs_q <= BufW'(bufs_q - BufW'(1));
          ae_q      <= seq_inc(ae_q);
          ae_slot_q <= slot_inc(ae_slot_q, ae_q);
        end
        CMD_POP: begin
          rd_q <= cnt_t'(rd_q + cnt_t'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      op_q   <= operation_i;
      kind_q <= frame_type_i;
      seq_q  <= seq_t'(reduce_seq(9'(frame_seq_i)));
      ack_q  <= seq_t'(reduce_seq(9'(frame_ack_i)));
      tseq_q <= seq_t'(reduce_seq(9'(timed_out_seq_i)));
    end
    if (push && (cnt_q < cnt_t'(ResultCap))) q_mem[cnt_q] <= push_ent;
  end

  assign status_o.op              = op_q;
  assign status_o.kind            = kind_q;
  assign status_o.deliver_pending = map_q[rle_slot_q];
  assign status_o.stop_pending    = stop_ok;
  assign status_o.last            = (cnt_t'(rd_q + cnt_t'(1)) == cnt_q);

  assign head_o           = q_mem[rd_q];
  assign network_enable_o = pkt_ok;

  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(ResultCap))
    else $error("result count above cap");

  a_bufs_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bufs_q <= BufW'(BUFFER_COUNT))
    else $error("buffers in use above buffer count");

  a_finish_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FINISH) |=> (cnt_q != '0))
    else $error("event finished with empty result queue");

  a_pop_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_POP) |-> (rd_q < cnt_q))
    else $error("pop past end of result queue");

endmodule

// ----- hw/rtl/srarq_ctrl.sv -----
// Event sequencer of the ARQ core: walks each event and drains its results.
module srarq_ctrl import srarq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_DECODE  = 9'b000000010,
    ST_ARR_NAK = 9'b000000100,
    ST_MARK    = 9'b000001000,
    ST_DELIVER = 9'b000010000,
    ST_RETX    = 9'b000100000,
    ST_STOP    = 9'b001000000,
    ST_FINISH  = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        case (status_i.op)
          OP_PKT_READY:   cmd_o = CMD_PKT;
          OP_CKSUM_ERR:   cmd_o = CMD_CKERR;
          OP_TIMEOUT:     cmd_o = CMD_TIMEOUT;
          OP_ACK_TIMEOUT: cmd_o = CMD_ACKTO;
          OP_FRAME: begin
            case (status_i.kind)
              KIND_DATA: state_d = ST_ARR_NAK;
              KIND_NAK:  state_d = ST_RETX;
              default:   state_d = ST_STOP;  // ack and the spare kind
            endcase
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_ARR_NAK: begin
        cmd_o   = CMD_ARR_NAK;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        cmd_o   = CMD_MARK;
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (status_i.deliver_pending) cmd_o = CMD_DELIVER;
        else state_d = ST_STOP;
      end
      ST_RETX: begin
        cmd_o   = CMD_RETX;
        state_d = ST_STOP;
      end
      ST_STOP: begin
        // cumulative ack runs for every arriving frame
        if (status_i.stop_pending) cmd_o = CMD_STOP;
        else state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o   = CMD_FINISH;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          cmd_o = CMD_POP;
          if (status_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  a_one_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input open while results pending");

  a_no_early_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result beat right after event beat");

  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.last) |=> in_ready_o)
    else $error("input not reopened after last beat");

endmodule
